// ----- sv/dctt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dctt_pkg: shared types and constants for the deferred call timer table
// Slot count, field widths, opcode and result kind codes, and the command
// word that travels from the front end through the queue to the slot engine.
// ----------------------------------------------------------------------------
package dctt_pkg;

   // table size (1..64)
   localparam int SLOTS   = 8;
   localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // fixed field widths
   localparam int ID_W   = 8;
   localparam int TIME_W = 32;
   localparam int SLOT_W = 6;
   localparam int KIND_W = 3;

   // command queue depth, power of two
   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   typedef logic [SLOT_IW-1:0] slot_idx_type;

   typedef enum logic {
      OP_DEFER   = 1'b0,
      OP_PROCESS = 1'b1
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPTED  = 3'd0,
      KIND_DUPLICATE = 3'd1,
      KIND_FULL      = 3'd2,
      KIND_FIRED     = 3'd3,
      KIND_NONE      = 3'd4
   } kind_type;

   // classified command; tim is the target for a defer, now for a process
   typedef struct packed {
      opcode_type        op;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] tim;
   } cmd_type;

endpackage
`default_nettype wire

// ----- sv/dctt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dctt_front: request intake
// Takes request words, works out the defer target (now + delay, wrapping at
// 32 bits) and holds the classified command until the queue takes it.
// ----------------------------------------------------------------------------
module dctt_front
   import dctt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_opcode,
   input  wire logic [ID_W-1:0]   req_callback_id,
   input  wire logic [TIME_W-1:0] req_delay_ms,
   input  wire logic [TIME_W-1:0] req_now_ms,
   output logic                   q_push,
   output cmd_type                q_cmd,
   input  wire logic              q_full
);

   logic    front_valid_ff;
   cmd_type cmd_ff;
   cmd_type cmd_in;

   // hold off new words only while the stage is occupied and the queue is full
   assign req_stall = front_valid_ff & q_full;
   assign q_push    = front_valid_ff & ~q_full;
   assign q_cmd     = cmd_ff;

   // classify the incoming word
   always_comb begin
      cmd_in.op = opcode_type'(req_opcode);
      cmd_in.id = req_callback_id;
      if (cmd_in.op == OP_DEFER) begin
         cmd_in.tim = req_now_ms + req_delay_ms;
      end else begin
         cmd_in.tim = req_now_ms;
      end
   end

   // intake stage
   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/dctt_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dctt_queue: command queue
// Small register FIFO between the front end and the slot engine so that each
// side stalls on its own.
// ----------------------------------------------------------------------------
module dctt_queue
   import dctt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   cmd_type             mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]     wr_ptr_ff;
   logic [Q_AW-1:0]     rd_ptr_ff;
   logic [Q_CW-1:0]     count_ff;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == Q_CW'(Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!do_push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- sv/dctt_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dctt_engine: slot table and sequencer
// Holds the timer slots. A defer does a duplicate search and lowest-free-slot
// pick over the table. A process walks the slots one per cycle unless a fire
// waits on the output; each fire is held back so the final one carries last.
// ----------------------------------------------------------------------------
module dctt_engine
   import dctt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire cmd_type           q_cmd,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [ID_W-1:0]        rsp_callback_id_res,
   output logic [SLOT_W-1:0]      rsp_slot,
   output logic                   rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   localparam slot_idx_type LAST_IDX = slot_idx_type'(SLOTS - 1);

   // slot table
   logic [ID_W-1:0]   slot_id_ff      [SLOTS];
   logic [TIME_W-1:0] slot_target_ff  [SLOTS];
   logic              slot_pending_ff [SLOTS];

   state_type         state_ff;
   logic [TIME_W-1:0] now_ff;
   slot_idx_type      scan_idx_ff;
   logic              held_valid_ff;
   logic [ID_W-1:0]   held_id_ff;
   slot_idx_type      held_idx_ff;

   logic              rsp_valid_ff;
   kind_type          rsp_kind_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_last_ff;

   logic              out_free;
   logic              dup_hit;
   slot_idx_type      dup_idx;
   logic              free_hit;
   slot_idx_type      free_idx;
   logic              cur_fire;
   logic              scan_hold;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_callback_id_res = rsp_id_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_last            = rsp_last_ff;

   // output register can take a word this cycle
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // lowest pending slot with the same id, lowest free slot
   always_comb begin
      dup_hit  = 1'b0;
      dup_idx  = '0;
      free_hit = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slot_pending_ff[i] && (slot_id_ff[i] == q_cmd.id)) begin
            dup_hit = 1'b1;
            dup_idx = slot_idx_type'(i);
         end
         if (!slot_pending_ff[i]) begin
            free_hit = 1'b1;
            free_idx = slot_idx_type'(i);
         end
      end
   end

   // expiry test on the slot under scan: strictly earlier, no wrap handling
   assign cur_fire  = slot_pending_ff[scan_idx_ff] &&
                      (now_ff > slot_target_ff[scan_idx_ff]);
   // a second fire must wait until the held one can be sent out
   assign scan_hold = cur_fire & held_valid_ff & ~out_free;

   assign q_pop = (state_ff == ST_IDLE) & q_valid & out_free;

   // sequencer, table and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_pending_ff[i] <= 1'b0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  if (q_cmd.op == OP_DEFER) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_last_ff  <= 1'b1;
                     rsp_id_ff    <= q_cmd.id;
                     if (dup_hit) begin
                        rsp_kind_ff <= KIND_DUPLICATE;
                        rsp_slot_ff <= SLOT_W'(dup_idx);
                     end else if (free_hit) begin
                        rsp_kind_ff               <= KIND_ACCEPTED;
                        rsp_slot_ff               <= SLOT_W'(free_idx);
                        slot_id_ff[free_idx]      <= q_cmd.id;
                        slot_target_ff[free_idx]  <= q_cmd.tim;
                        slot_pending_ff[free_idx] <= 1'b1;
                     end else begin
                        rsp_kind_ff <= KIND_FULL;
                        rsp_slot_ff <= '0;
                     end
                  end else begin
                     now_ff        <= q_cmd.tim;
                     scan_idx_ff   <= '0;
                     held_valid_ff <= 1'b0;
                     state_ff      <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (!scan_hold) begin
                  if (cur_fire) begin
                     if (held_valid_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_kind_ff  <= KIND_FIRED;
                        rsp_id_ff    <= held_id_ff;
                        rsp_slot_ff  <= SLOT_W'(held_idx_ff);
                        rsp_last_ff  <= 1'b0;
                     end
                     held_valid_ff                <= 1'b1;
                     held_id_ff                   <= slot_id_ff[scan_idx_ff];
                     held_idx_ff                  <= scan_idx_ff;
                     slot_pending_ff[scan_idx_ff] <= 1'b0;
                  end
                  if (scan_idx_ff == LAST_IDX) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     scan_idx_ff <= scan_idx_ff + 1'b1;
                  end
               end
            end
            ST_FLUSH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= 1'b1;
                  if (held_valid_ff) begin
                     rsp_kind_ff <= KIND_FIRED;
                     rsp_id_ff   <= held_id_ff;
                     rsp_slot_ff <= SLOT_W'(held_idx_ff);
                  end else begin
                     rsp_kind_ff <= KIND_NONE;
                     rsp_id_ff   <= '0;
                     rsp_slot_ff <= '0;
                  end
                  held_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- sv/deferred_call_timer_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deferred_call_timer_table: one-shot timer slot table
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall  opcode, callback id, delay, now
//   rsp_     out        rsp_valid/rsp_stall  kind, callback id, slot, last
//
// A defer word is resolved in the slot engine by a parallel id match and
// free-slot pick. A process word is taken from the queue, then each slot is
// compared for expiry in slot order, then the final result is sent.
// The front stage and a 2-word queue keep taking requests while the engine
// works. Reset is synchronous and frees every slot at once.
// rsp_stall holds the output register; a process scan pauses on a fire that
// cannot be sent.
// ----------------------------------------------------------------------------
module deferred_call_timer_table
   import dctt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_opcode,
   input  wire logic [ID_W-1:0]   req_callback_id,
   input  wire logic [TIME_W-1:0] req_delay_ms,
   input  wire logic [TIME_W-1:0] req_now_ms,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [ID_W-1:0]        rsp_callback_id_res,
   output logic [SLOT_W-1:0]      rsp_slot,
   output logic                   rsp_last
);

   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_head;

   // intake and classification
   dctt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_callback_id (req_callback_id),
      .req_delay_ms    (req_delay_ms),
      .req_now_ms      (req_now_ms),
      .q_push          (q_push),
      .q_cmd           (q_push_cmd),
      .q_full          (q_full)
   );

   // command queue
   dctt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head)
   );

   // slot table and result sequencing
   dctt_engine u_engine (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_cmd               (q_head),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_callback_id_res (rsp_callback_id_res),
      .rsp_slot            (rsp_slot),
      .rsp_last            (rsp_last)
   );

endmodule
`default_nettype wire

// ----- dv/deferred_call_timer_table_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deferred_call_timer_table_test: self-checking bench for the timer slot table
// A directed table of request words covers the empty and full table, duplicate
// ids, equal time, target wrap and the field extremes. A random phase of armed
// and expiring callbacks follows on a moving time base. Every result word is
// checked against its typed row or else a local model of the slot table.
// Both channels idle at random, the receiver once holds off long enough to back
// up the request side, and the sender once drains the block before going on.
// ----------------------------------------------------------------------------
module deferred_call_timer_table_test;
   import dctt_pkg::*;

   localparam int          RANDOM_WORDS  = 91;
   localparam int          PLAN_ROWS     = 19;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int          SETTLE_CYCLES = 2 * SLOTS + 8;
   localparam int          HOLD_CYCLES   = 300;

   // one result word as the table should report it
   typedef struct {
      kind_type          kind;
      logic [ID_W-1:0]   id;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } timer_event_type;

   // one directed request; typed rows carry their single result word
   typedef struct packed {
      opcode_type        op;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] now;
      logic              typed;
      kind_type          kind;
      logic [ID_W-1:0]   res_id;
      logic [SLOT_W-1:0] slot;
   } plan_row_type;

   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // empty table, ignored fields low then high
      '{OP_PROCESS, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_NONE, 8'h00, 6'd0},
      '{OP_PROCESS, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, KIND_NONE, 8'h00, 6'd0},
      // arm id 0 at target 0, then repeat it
      '{OP_DEFER,   8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_ACCEPTED, 8'h00, 6'd0},
      '{OP_DEFER,   8'h00, 32'h0000_0005, 32'h0000_0007, 1'b1, KIND_DUPLICATE, 8'h00, 6'd0},
      // target equal to now does not fire
      '{OP_PROCESS, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_NONE, 8'h00, 6'd0},
      // target wraps past 2^32
      '{OP_DEFER,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, KIND_ACCEPTED, 8'hFF, 6'd1},
      '{OP_DEFER,   8'hA5, 32'h0000_000A, 32'hFFFF_FFFA, 1'b1, KIND_ACCEPTED, 8'hA5, 6'd2},
      // fill the rest of the table
      '{OP_DEFER,   8'h01, 32'h0000_0064, 32'h0000_0005, 1'b0, KIND_NONE, 8'h00, 6'd0},
      '{OP_DEFER,   8'h02, 32'h0000_0003, 32'h0000_0005, 1'b0, KIND_NONE, 8'h00, 6'd0},
      '{OP_DEFER,   8'h03, 32'h0000_0000, 32'h0000_0001, 1'b0, KIND_NONE, 8'h00, 6'd0},
      '{OP_DEFER,   8'h80, 32'h8000_0000, 32'h0000_0001, 1'b0, KIND_NONE, 8'h00, 6'd0},
      '{OP_DEFER,   8'h7F, 32'h0000_0002, 32'h0000_0000, 1'b0, KIND_NONE, 8'h00, 6'd0},
      // full table drops, but a duplicate still wins over full
      '{OP_DEFER,   8'h4D, 32'h0000_0001, 32'h0000_0001, 1'b1, KIND_FULL, 8'h4D, 6'd0},
      '{OP_DEFER,   8'hFF, 32'h0000_0001, 32'h0000_0001, 1'b1, KIND_DUPLICATE, 8'hFF, 6'd1},
      // several fires in slot order, slot reuse, late sweep
      '{OP_PROCESS, 8'h00, 32'h0000_0000, 32'h0000_0005, 1'b0, KIND_NONE, 8'h00, 6'd0},
      '{OP_DEFER,   8'h55, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, KIND_NONE, 8'h00, 6'd0},
      '{OP_PROCESS, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, KIND_NONE, 8'h00, 6'd0},
      '{OP_DEFER,   8'h55, 32'h0000_0000, 32'h0000_0000, 1'b0, KIND_NONE, 8'h00, 6'd0},
      '{OP_PROCESS, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_NONE, 8'h00, 6'd0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_opcode = 1'b0;
   logic [ID_W-1:0]   req_callback_id = '0;
   logic [TIME_W-1:0] req_delay_ms = '0;
   logic [TIME_W-1:0] req_now_ms = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [ID_W-1:0]   rsp_callback_id_res;
   logic [SLOT_W-1:0] rsp_slot;
   logic              rsp_last;

   // typed expectation riding along with the request word
   logic              row_typed = 1'b0;
   kind_type          row_kind = KIND_NONE;
   logic [ID_W-1:0]   row_id = '0;
   logic [SLOT_W-1:0] row_slot = '0;

   // local copy of the slot table
   bit                slot_armed  [SLOTS];
   bit [ID_W-1:0]     slot_id     [SLOTS];
   bit [TIME_W-1:0]   slot_target [SLOTS];

   timer_event_type   due_events [$];
   int unsigned       fail_count = 0;
   int unsigned       cycle_count = 0;
   int unsigned       req_idle_pct = 27;
   int unsigned       rsp_idle_pct = 72;
   logic              hold_go = 1'b0;
   logic              hold_used = 1'b0;
   int unsigned       hold_left = 0;

   deferred_call_timer_table i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_callback_id     (req_callback_id),
      .req_delay_ms        (req_delay_ms),
      .req_now_ms          (req_now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_callback_id_res (rsp_callback_id_res),
      .rsp_slot            (rsp_slot),
      .rsp_last            (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // apply one request word to the slot table, queue its result words if asked
   function automatic void advance_timer_table(input opcode_type op,
                                               input logic [ID_W-1:0] id,
                                               input logic [TIME_W-1:0] delay,
                                               input logic [TIME_W-1:0] now,
                                               input bit emit);
      timer_event_type burst [$];
      timer_event_type ev;
      int              hit;
      int              free_slot;
      int              s;
      hit = -1;
      free_slot = -1;
      if (op == OP_DEFER) begin
         for (s = 0; s < SLOTS; s++) begin
            if (hit < 0 && slot_armed[s] && slot_id[s] == id) hit = s;
            if (free_slot < 0 && !slot_armed[s]) free_slot = s;
         end
         ev.id = id;
         ev.last = 1'b1;
         if (hit >= 0) begin
            ev.kind = KIND_DUPLICATE;
            ev.slot = SLOT_W'(hit);
         end else if (free_slot < 0) begin
            ev.kind = KIND_FULL;
            ev.slot = '0;
         end else begin
            slot_armed[free_slot] = 1'b1;
            slot_id[free_slot] = id;
            slot_target[free_slot] = now + delay;
            ev.kind = KIND_ACCEPTED;
            ev.slot = SLOT_W'(free_slot);
         end
         burst.push_back(ev);
      end else begin
         // fire in slot order; plain unsigned compare, equal does not fire
         for (s = 0; s < SLOTS; s++) begin
            if (slot_armed[s] && now > slot_target[s]) begin
               ev.kind = KIND_FIRED;
               ev.id = slot_id[s];
               ev.slot = SLOT_W'(s);
               ev.last = 1'b0;
               slot_armed[s] = 1'b0;
               burst.push_back(ev);
            end
         end
         if (burst.size() == 0) begin
            ev.kind = KIND_NONE;
            ev.id = '0;
            ev.slot = '0;
            ev.last = 1'b1;
            burst.push_back(ev);
         end else begin
            burst[burst.size() - 1].last = 1'b1;
         end
      end
      if (emit) begin
         foreach (burst[k]) due_events.push_back(burst[k]);
      end
   endfunction

   // result check first, then predict the word accepted at this edge
   always @(posedge clock) begin : scoreboard
      timer_event_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_events.size() == 0) begin
               $error("unexpected result word: kind %0d id %0d slot %0d",
                      rsp_kind, rsp_callback_id_res, rsp_slot);
               fail_count++;
            end else begin
               want = due_events.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_callback_id_res !== want.id) begin
                  $error("callback_id_res: expected %0d, got %0d", want.id,
                         rsp_callback_id_res);
                  fail_count++;
               end
               if (rsp_slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            advance_timer_table(opcode_type'(req_opcode), req_callback_id, req_delay_ms,
                                req_now_ms, !row_typed);
            if (row_typed) begin
               want.kind = row_kind;
               want.id = row_id;
               want.slot = row_slot;
               want.last = 1'b1;
               due_events.push_back(want);
            end
         end
      end
   end

   // receiver: random stall, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_used) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("deferred_call_timer_table verification failed");
         $finish;
      end
   end

   // offer one request word and hold it until accepted
   task automatic offer_word(input opcode_type op, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] delay, input logic [TIME_W-1:0] now,
                             input logic typed, input kind_type kind,
                             input logic [ID_W-1:0] res_id, input logic [SLOT_W-1:0] slot);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_callback_id <= id;
      req_delay_ms    <= delay;
      req_now_ms      <= now;
      row_typed       <= typed;
      row_kind        <= kind;
      row_id          <= res_id;
      row_slot        <= slot;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin : stimulus
      logic [TIME_W-1:0] now_base;
      int unsigned       pick;
      logic [ID_W-1:0]   id;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (PLAN[r]) begin
         offer_word(PLAN[r].op, PLAN[r].id, PLAN[r].delay, PLAN[r].now, PLAN[r].typed,
                    PLAN[r].kind, PLAN[r].res_id, PLAN[r].slot);
      end

      // random callbacks on a moving time base
      now_base = $urandom;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 3) begin
            req_idle_pct = 72;
            rsp_idle_pct <= 27;
         end
         if (n == 2 * RANDOM_WORDS / 3) begin
            req_idle_pct = 0;
            rsp_idle_pct <= 0;
         end
         // drain the block completely once
         if (n == RANDOM_WORDS / 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (due_events.size() != 0);
         end
         // long receiver hold-off while words keep coming
         if (n == 3 * RANDOM_WORDS / 4) hold_go <= 1'b1;

         pick = $urandom_range(99);
         id = ($urandom_range(3) != 0) ? ID_W'($urandom_range(11)) : ID_W'($urandom);
         if (pick < 55) begin
            offer_word(OP_DEFER, id,
                       ($urandom_range(9) == 0) ? TIME_W'($urandom)
                                                : TIME_W'($urandom_range(40)),
                       now_base, 1'b0, KIND_NONE, '0, '0);
         end else if (pick < 88) begin
            now_base = now_base + $urandom_range(30);
            offer_word(OP_PROCESS, ID_W'($urandom), TIME_W'($urandom), now_base,
                       1'b0, KIND_NONE, '0, '0);
         end else begin
            // noise: every field anywhere in its range
            offer_word(opcode_type'($urandom_range(1)), ID_W'($urandom), TIME_W'($urandom),
                       TIME_W'($urandom), 1'b0, KIND_NONE, '0, '0);
         end
      end
      req_valid <= 1'b0;

      // wait out the remaining results, then watch for strays
      do @(posedge clock); while (due_events.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("deferred_call_timer_table verification clean");
      end else begin
         $display("deferred_call_timer_table verification failed");
      end
      $finish;
   end

endmodule
